// ----- rtl/core/trpc_pkg.sv -----
// Shared constants and types for the tricolour ratio point check block.
package trpc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Fixed field widths on the streaming ports.
    localparam int IN_SAMPLE_W = 12;
    localparam int LIMIT_W     = 16;
    localparam int MODE_W      = 3;
    localparam int RATIO_W     = 11;
    localparam int COUNT_W     = 16;
    localparam int LEVEL_W     = 7;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 40;

    // Configuration register widths and port layout.
    localparam int MULT_W     = 10;
    localparam int MARGIN_W   = 12;
    localparam int STD_W      = 8;
    localparam int STEP_W     = 8;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_MULT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STD_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP = 2'd3;

    localparam logic [MULT_W-1:0]   RATIO_MULT_RST = 10'd100;
    localparam logic [MARGIN_W-1:0] MARGIN_RST     = 12'd0;
    localparam logic [STD_W-1:0]    STD_LEVEL_RST  = 8'd100;
    localparam logic [STEP_W-1:0]   LEVEL_STEP_RST = 8'd10;

    // Channel pairing codes.
    localparam logic [MODE_W-1:0] MODE_IR_RED_FIRST    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_IR_RED_LAST     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_IR_GREEN_FIRST  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_IR_GREEN_LAST   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GREEN_RED_FIRST = 3'd4;
    localparam logic [MODE_W-1:0] MODE_GREEN_RED_LAST  = 3'd7;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_MIN = 7'd1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // The quotient is bounded below 2^RATIO_W, so that many divide steps suffice.
    localparam int DIV_CNT_W = $clog2(RATIO_W);

    typedef struct packed {
        logic [MULT_W-1:0]   ratio_mult;
        logic [MARGIN_W-1:0] margin;
        logic [STD_W-1:0]    std_level;
        logic [STEP_W-1:0]   step;
    } cfg_t;

endpackage

// ----- rtl/core/tricolour_ratio_point_check.sv -----
// Top level of the tricolour ratio point check block.
//
// Check points arrive on the s_axis channel: samples and limits in tdata,
// the channel pairing mode in tuser and the final-point mark in tlast.
// Each request yields one result on m_axis: ratio, fail flag, running fail
// count and level in tdata, with tlast set on the result of the last point.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// A point passes through the evaluation engine in order: pop, multiply, eleven
// restoring divide steps, limit test, output load. The engine takes the next
// point from the queue only after it has loaded the result of the last one.
//
// A queue in front of the engine keeps taking points while a result waits;
// when the receiver stalls, the engine holds in its output step and the
// queue fills, after which s_axis_tready drops.
// Reset clears the queue, the tally and the output valid, and loads the
// register defaults (multiplier 100, margin 0, standard 100, step 10).
module tricolour_ratio_point_check #(
    parameter int SAMPLE_BITS = trpc_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = trpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // ir_sample, red_sample, green_sample, lower_limit, upper_limit, zero fill
    input  logic [trpc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // mode
    input  logic [trpc_pkg::MODE_W-1:0]     s_axis_tuser,
    input  logic                            s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // ratio, point_failed, fail_count, level, zero fill
    output logic [trpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            cfg_we,
    input  logic [trpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [trpc_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ENTRY_W = 2 * SAMPLE_BITS + 3 + 2 * trpc_pkg::LIMIT_W + 1;

    trpc_pkg::cfg_t     cfg_reg;
    logic [ENTRY_W-1:0] push_entry;
    logic [ENTRY_W-1:0] pop_entry;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    logic               q_push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ratio_mult <= trpc_pkg::RATIO_MULT_RST;
            cfg_reg.margin     <= trpc_pkg::MARGIN_RST;
            cfg_reg.std_level  <= trpc_pkg::STD_LEVEL_RST;
            cfg_reg.step       <= trpc_pkg::LEVEL_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                trpc_pkg::CFG_RATIO_MULT: cfg_reg.ratio_mult <= cfg_data[trpc_pkg::MULT_W-1:0];
                trpc_pkg::CFG_MARGIN:     cfg_reg.margin     <= cfg_data[trpc_pkg::MARGIN_W-1:0];
                trpc_pkg::CFG_STD_LEVEL:  cfg_reg.std_level  <= cfg_data[trpc_pkg::STD_W-1:0];
                trpc_pkg::CFG_LEVEL_STEP: cfg_reg.step       <= cfg_data[trpc_pkg::STEP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    trpc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .entry        (push_entry)
    );

    trpc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_entry),
        .empty     (q_empty)
    );

    trpc_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .entry         (pop_entry),
        .entry_empty   (q_empty),
        .entry_pop     (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- rtl/core/trpc_front.sv -----
// Front end: accepts check points, forms the channel difference and the clamped sum.
module trpc_front #(
    parameter int SAMPLE_BITS = trpc_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 3 + 2 * trpc_pkg::LIMIT_W + 1
) (
    input  logic [trpc_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic [trpc_pkg::MODE_W-1:0]    s_axis_tuser,
    input  logic                           s_axis_tlast,
    output logic [ENTRY_W-1:0]             entry
);

    localparam int DW   = SAMPLE_BITS + 1;
    localparam int SUMW = SAMPLE_BITS + 2;

    logic [SAMPLE_BITS-1:0] ir;
    logic [SAMPLE_BITS-1:0] red;
    logic [SAMPLE_BITS-1:0] grn;
    logic [DW-1:0]          dbl;
    logic [DW-1:0]          sub;
    logic [DW-1:0]          diff;
    logic [SUMW-1:0]        sum_raw;
    logic [SUMW-1:0]        sum;

    assign ir  = SAMPLE_BITS'(s_axis_tdata[11:0]);
    assign red = SAMPLE_BITS'(s_axis_tdata[23:12]);
    assign grn = SAMPLE_BITS'(s_axis_tdata[35:24]);

    always_comb
    begin
        if (s_axis_tuser inside {[trpc_pkg::MODE_IR_RED_FIRST:trpc_pkg::MODE_IR_RED_LAST]})
        begin
            dbl = {ir, 1'b0};
            sub = DW'(red);
        end
        else if (s_axis_tuser inside
                 {[trpc_pkg::MODE_IR_GREEN_FIRST:trpc_pkg::MODE_IR_GREEN_LAST]})
        begin
            dbl = {ir, 1'b0};
            sub = DW'(grn);
        end
        else
        begin
            dbl = {grn, 1'b0};
            sub = DW'(red);
        end
        diff = (dbl >= sub) ? (dbl - sub) : (sub - dbl);
    end

    assign sum_raw = SUMW'(ir) + SUMW'(red) + SUMW'(grn);
    assign sum     = (sum_raw == '0) ? SUMW'(1) : sum_raw;

    // Entry layout from the top: last, upper, lower, sum, diff.
    assign entry = {s_axis_tlast, s_axis_tdata[67:52], s_axis_tdata[51:36], sum, diff};

endmodule

// ----- rtl/core/trpc_queue.sv -----
// Small register queue between the front end and the evaluation engine.
module trpc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = trpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/trpc_back.sv -----
// Evaluation engine: scaling, serial division, limit test, failure tally and level.
module trpc_back #(
    parameter int SAMPLE_BITS = trpc_pkg::SAMPLE_BITS_DEF,
    parameter int ENTRY_W     = 2 * SAMPLE_BITS + 3 + 2 * trpc_pkg::LIMIT_W + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  trpc_pkg::cfg_t                  cfg,
    input  logic [ENTRY_W-1:0]              entry,
    input  logic                            entry_empty,
    output logic                            entry_pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [trpc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tlast
);

    localparam int DW   = SAMPLE_BITS + 1;
    localparam int SUMW = SAMPLE_BITS + 2;
    localparam int PW   = DW + trpc_pkg::MULT_W;
    localparam int RW   = trpc_pkg::RATIO_W;
    localparam int LW   = trpc_pkg::LIMIT_W;
    localparam int CW   = trpc_pkg::COUNT_W;
    localparam int TW   = LW + 1;
    localparam int LPW  = trpc_pkg::STEP_W + CW;

    typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_EVAL, ST_OUT} state_t;

    state_t                        state_reg;
    logic [DW-1:0]                 diff_reg;
    logic [SUMW-1:0]               sum_reg;
    logic [LW-1:0]                 lo_reg;
    logic [LW-1:0]                 hi_reg;
    logic                          last_reg;
    logic [SUMW-1:0]               rem_reg;
    logic [RW-1:0]                 quo_reg;
    logic [trpc_pkg::DIV_CNT_W-1:0] step_cnt_reg;
    logic                          fail_reg;
    logic [CW-1:0]                 cnt_reg;
    logic                          out_valid_reg;
    logic [RW-1:0]                 out_ratio_reg;
    logic                          out_fail_reg;
    logic [CW-1:0]                 out_count_reg;
    logic [trpc_pkg::LEVEL_W-1:0]  out_level_reg;
    logic                          out_last_reg;

    logic [PW-1:0]                 prod;
    logic [SUMW:0]                 trial;
    logic [SUMW:0]                 trial_sub;
    logic                          trial_ge;
    logic [SUMW-1:0]               rem_next;
    logic                          fail_now;
    logic [TW-1:0]                 ratio_ext;
    logic [CW-1:0]                 cnt_next;
    logic [LPW-1:0]                lvl_prod;
    logic [trpc_pkg::STD_W-1:0]    lvl_diff;
    logic [trpc_pkg::LEVEL_W-1:0]  level_now;
    logic                          out_free;

    assign prod = PW'(diff_reg) * PW'(cfg.ratio_mult);

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    assign trial     = {rem_reg, quo_reg[RW-1]};
    assign trial_sub = trial - {1'b0, sum_reg};
    assign trial_ge  = (trial >= {1'b0, sum_reg});
    assign rem_next  = trial_ge ? trial_sub[SUMW-1:0] : trial[SUMW-1:0];

    assign ratio_ext = TW'(quo_reg);
    assign fail_now  = ((ratio_ext + TW'(cfg.margin)) < TW'(lo_reg)) ||
                       (ratio_ext > (TW'(hi_reg) + TW'(cfg.margin)));
    assign cnt_next  = (fail_now && (cnt_reg != trpc_pkg::COUNT_MAX)) ? cnt_reg + 1'b1
                                                                      : cnt_reg;

    always_comb
    begin
        lvl_prod = LPW'(cfg.step) * LPW'(cnt_reg);
        lvl_diff = cfg.std_level - lvl_prod[trpc_pkg::STD_W-1:0];
        if (lvl_prod >= LPW'(cfg.std_level))
        begin
            level_now = trpc_pkg::LEVEL_MIN;
        end
        else if (lvl_diff > trpc_pkg::STD_W'(trpc_pkg::LEVEL_MAX))
        begin
            level_now = trpc_pkg::LEVEL_MAX;
        end
        else
        begin
            level_now = trpc_pkg::LEVEL_W'(lvl_diff);
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign entry_pop = (state_reg == ST_IDLE) && !entry_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (!entry_empty)
                    begin
                        diff_reg  <= entry[DW-1:0];
                        sum_reg   <= entry[DW+SUMW-1:DW];
                        lo_reg    <= entry[DW+SUMW+LW-1:DW+SUMW];
                        hi_reg    <= entry[DW+SUMW+2*LW-1:DW+SUMW+LW];
                        last_reg  <= entry[ENTRY_W-1];
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    // The high part of the product is already below the divisor.
                    rem_reg      <= SUMW'(prod[PW-1:RW]);
                    quo_reg      <= prod[RW-1:0];
                    step_cnt_reg <= trpc_pkg::DIV_CNT_W'(RW - 1);
                    state_reg    <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[RW-2:0], trial_ge};
                    if (step_cnt_reg == '0)
                    begin
                        state_reg <= ST_EVAL;
                    end
                    else
                    begin
                        step_cnt_reg <= step_cnt_reg - 1'b1;
                    end
                end
                ST_EVAL:
                begin
                    fail_reg  <= fail_now;
                    cnt_reg   <= cnt_next;
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_ratio_reg <= quo_reg;
                        out_fail_reg  <= fail_reg;
                        out_count_reg <= cnt_reg;
                        out_level_reg <= last_reg ? level_now : '0;
                        out_last_reg  <= last_reg;
                        if (last_reg)
                        begin
                            cnt_reg <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'b0, out_level_reg, out_count_reg, out_fail_reg, out_ratio_reg};

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < sum_reg))
        else $error("division remainder not below the sum");

    a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (12'(out_ratio_reg) <= {1'b0, cfg.ratio_mult, 1'b0}))
        else $error("ratio exceeds twice the multiplier");

    a_level_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg ? (out_level_reg != '0) : (out_level_reg == '0)))
        else $error("level does not match the last-point flag");

    a_tally_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_OUT) && out_free && last_reg) |=> (cnt_reg == '0))
        else $error("failure tally not cleared after the last point");

endmodule

// ----- dv/tricolour_ratio_point_check_tb.sv -----
// Self-checking testbench for the tricolour ratio point check block.
module tricolour_ratio_point_check_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_HOLD = 300;

    // Check point request as it appears on the input side.
    typedef struct {
        logic [trpc_pkg::MODE_W-1:0]      mode;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] ir;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] red;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] green;
        logic [trpc_pkg::LIMIT_W-1:0]     lo;
        logic [trpc_pkg::LIMIT_W-1:0]     hi;
        logic                             last;
    } point_t;

    typedef struct {
        logic [trpc_pkg::RATIO_W-1:0] ratio;
        logic                         failed;
        logic [trpc_pkg::COUNT_W-1:0] count;
        logic [trpc_pkg::LEVEL_W-1:0] level;
        logic                         done;
    } point_result_t;

    // Bit layouts of the two data buses, last field in the lowest bits.
    typedef struct packed {
        logic [3:0]                       fill;
        logic [trpc_pkg::LIMIT_W-1:0]     hi;
        logic [trpc_pkg::LIMIT_W-1:0]     lo;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] green;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] red;
        logic [trpc_pkg::IN_SAMPLE_W-1:0] ir;
    } point_bus_t;

    typedef struct packed {
        logic [4:0]                   fill;
        logic [trpc_pkg::LEVEL_W-1:0] level;
        logic [trpc_pkg::COUNT_W-1:0] count;
        logic                         failed;
        logic [trpc_pkg::RATIO_W-1:0] ratio;
    } result_bus_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [trpc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [trpc_pkg::MODE_W-1:0]     s_axis_tuser = '0;
    logic                            s_axis_tlast = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [trpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            cfg_we = 1'b0;
    logic [trpc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [trpc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Shadow copy of the block's registers and failure tally.
    logic [trpc_pkg::MULT_W-1:0]   mult_model = trpc_pkg::RATIO_MULT_RST;
    logic [trpc_pkg::MARGIN_W-1:0] margin_model = trpc_pkg::MARGIN_RST;
    logic [trpc_pkg::STD_W-1:0]    std_model = trpc_pkg::STD_LEVEL_RST;
    logic [trpc_pkg::STEP_W-1:0]   step_model = trpc_pkg::LEVEL_STEP_RST;
    logic [trpc_pkg::COUNT_W-1:0]  tally_model = '0;

    point_result_t pending_results[$];

    int  mismatches = 0;
    int  cycle_count = 0;
    int  points_sent = 0;
    int  checks_closed = 0;
    int  failing_points = 0;
    int  settings_used = 1;
    int  hold_request = 0;
    bit  send_idle = 1'b1;
    bit  recv_idle = 1'b1;

    tricolour_ratio_point_check i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Computes the result of one point, advances the failure tally and clears it on the last point.
    function automatic point_result_t predict_point(point_t p);
        longint unsigned total;
        longint unsigned twice;
        longint unsigned other;
        longint unsigned diff;
        longint unsigned ratio;
        longint          lv;
        bit              fail;
        point_result_t   r;
        total = 64'(p.ir) + 64'(p.red) + 64'(p.green);
        if (total == 0)
            total = 1;
        if (p.mode <= trpc_pkg::MODE_IR_RED_LAST)
        begin
            twice = 2 * 64'(p.ir);
            other = 64'(p.red);
        end
        else if (p.mode <= trpc_pkg::MODE_IR_GREEN_LAST)
        begin
            twice = 2 * 64'(p.ir);
            other = 64'(p.green);
        end
        else
        begin
            twice = 2 * 64'(p.green);
            other = 64'(p.red);
        end
        diff = (twice >= other) ? twice - other : other - twice;
        ratio = diff * 64'(mult_model) / total;
        // Widened limits are compared at full signed precision.
        fail = (longint'(ratio) < longint'(p.lo) - longint'(margin_model)) ||
               (longint'(ratio) > longint'(p.hi) + longint'(margin_model));
        if (fail && tally_model != trpc_pkg::COUNT_MAX)
            tally_model = tally_model + 1'b1;
        r.ratio = ratio[trpc_pkg::RATIO_W-1:0];
        r.failed = fail;
        r.count = tally_model;
        r.level = '0;
        r.done = p.last;
        if (p.last)
        begin
            lv = longint'(std_model) - longint'(step_model) * longint'(tally_model);
            if (lv > longint'(trpc_pkg::LEVEL_MAX))
                lv = longint'(trpc_pkg::LEVEL_MAX);
            else if (lv <= 0)
                lv = longint'(trpc_pkg::LEVEL_MIN);
            r.level = lv[trpc_pkg::LEVEL_W-1:0];
            tally_model = '0;
        end
        return r;
    endfunction

    function automatic point_t make_point(int mode, int ir, int red, int green,
                                          int lo, int hi, bit last);
        point_t p;
        p.mode = mode[trpc_pkg::MODE_W-1:0];
        p.ir = ir[trpc_pkg::IN_SAMPLE_W-1:0];
        p.red = red[trpc_pkg::IN_SAMPLE_W-1:0];
        p.green = green[trpc_pkg::IN_SAMPLE_W-1:0];
        p.lo = lo[trpc_pkg::LIMIT_W-1:0];
        p.hi = hi[trpc_pkg::LIMIT_W-1:0];
        p.last = last;
        return p;
    endfunction

    function automatic int idle_cycles(bit enabled);
        return enabled ? int'($urandom_range(0, 15)) : 0;
    endfunction

    task automatic send_point(point_t p);
        int         gap;
        point_bus_t bus;
        gap = idle_cycles(send_idle);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bus = '{fill: '0, hi: p.hi, lo: p.lo, green: p.green, red: p.red, ir: p.ir};
        s_axis_tdata <= bus;
        s_axis_tuser <= p.mode;
        s_axis_tlast <= p.last;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(predict_point(p));
        points_sent++;
        if (p.last)
            checks_closed++;
    endtask

    // Waits until every expected result has been taken and the block is quiet.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [trpc_pkg::CFG_IDX_W-1:0] idx, int value);
        cfg_index <= idx;
        cfg_data <= value[trpc_pkg::CFG_DATA_W-1:0];
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            trpc_pkg::CFG_RATIO_MULT: mult_model = value[trpc_pkg::MULT_W-1:0];
            trpc_pkg::CFG_MARGIN:     margin_model = value[trpc_pkg::MARGIN_W-1:0];
            trpc_pkg::CFG_STD_LEVEL:  std_model = value[trpc_pkg::STD_W-1:0];
            trpc_pkg::CFG_LEVEL_STEP: step_model = value[trpc_pkg::STEP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int mult, int margin, int std_level, int step);
        drain_results();
        write_reg(trpc_pkg::CFG_RATIO_MULT, mult);
        write_reg(trpc_pkg::CFG_MARGIN, margin);
        write_reg(trpc_pkg::CFG_STD_LEVEL, std_level);
        write_reg(trpc_pkg::CFG_LEVEL_STEP, step);
        settings_used++;
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
                         name, cycle_count, want, got);
        end
    endtask

    // Result side: random stalls, a long hold on request, one check per result.
    initial
    begin : result_checker
        int            gap;
        result_bus_t   bus;
        point_result_t want;
        wait (rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                gap = hold_request;
                hold_request = 0;
            end
            else
                gap = idle_cycles(recv_idle);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            bus = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result at cycle %0d: data %h last %b",
                             cycle_count, m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.failed)
                    failing_points++;
                compare_field("ratio", want.ratio, bus.ratio);
                compare_field("point_failed", want.failed, bus.failed);
                compare_field("fail_count", want.count, bus.count);
                compare_field("level", want.level, bus.level);
                compare_field("done", want.done, m_axis_tlast);
            end
        end
    end

    // Field extremes, every pairing mode, zero sum, inverted and negative windows,
    // and the level clamps at both ends.
    task automatic test_directed();
        int m;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        send_point(make_point(trpc_pkg::MODE_IR_RED_FIRST, 0, 0, 0, 0, 0, 0));
        send_point(make_point(trpc_pkg::MODE_IR_RED_LAST, 4095, 0, 0, 0, 10, 0));
        send_point(make_point(trpc_pkg::MODE_IR_GREEN_FIRST, 0, 0, 4095, 0, 65535, 0));
        send_point(make_point(trpc_pkg::MODE_IR_GREEN_LAST, 1000, 2000, 3000, 200, 100, 0));
        for (m = trpc_pkg::MODE_GREEN_RED_FIRST; m <= trpc_pkg::MODE_GREEN_RED_LAST; m++)
            send_point(make_point(m, 4095, 4095, 4095, 0, 65535,
                                  m == trpc_pkg::MODE_GREEN_RED_LAST));
        send_point(make_point(trpc_pkg::MODE_IR_RED_FIRST, 0, 0, 0, 0, 0, 1));

        set_config(1023, 4095, 255, 0);
        send_point(make_point(trpc_pkg::MODE_IR_RED_FIRST, 4095, 0, 0, 0, 0, 0));
        send_point(make_point(trpc_pkg::MODE_IR_GREEN_LAST, 4095, 4095, 4095, 65535, 0, 0));
        send_point(make_point(trpc_pkg::MODE_GREEN_RED_LAST, 0, 4095, 0, 65535, 65535, 1));

        set_config(0, 0, 0, 255);
        send_point(make_point(trpc_pkg::MODE_IR_RED_LAST, 123, 456, 789, 0, 0, 1));

        set_config(1023, 0, 10, 255);
        send_point(make_point(trpc_pkg::MODE_GREEN_RED_LAST, 4095, 4095, 4095,
                              65535, 65535, 0));
        send_point(make_point(trpc_pkg::MODE_IR_GREEN_FIRST, 0, 0, 0, 1, 65535, 1));
        send_point(make_point(trpc_pkg::MODE_GREEN_RED_FIRST, 2048, 1, 4094, 65535, 0, 1));
    endtask

    function automatic logic [trpc_pkg::IN_SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return trpc_pkg::IN_SAMPLE_W'($urandom_range(0, 15));
            default: return trpc_pkg::IN_SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic point_t random_point(bit last);
        point_t      p;
        int unsigned span;
        int unsigned lo;
        span = 2 * int'(mult_model) + 1;
        p.mode = trpc_pkg::MODE_W'($urandom);
        p.ir = rand_sample();
        p.red = rand_sample();
        p.green = rand_sample();
        p.last = last;
        case ($urandom_range(0, 9))
            0:
            begin
                p.lo = trpc_pkg::LIMIT_W'($urandom);
                p.hi = trpc_pkg::LIMIT_W'($urandom);
            end
            1:
            begin
                lo = $urandom_range(1, 65535);
                p.lo = lo[trpc_pkg::LIMIT_W-1:0];
                p.hi = trpc_pkg::LIMIT_W'($urandom_range(0, lo - 1));
            end
            default:
            begin
                // Window inside the reachable ratio range gives a mix of passes and fails.
                lo = $urandom_range(0, span);
                p.lo = lo[trpc_pkg::LIMIT_W-1:0];
                p.hi = trpc_pkg::LIMIT_W'(lo + $urandom_range(0, span));
            end
        endcase
        return p;
    endfunction

    task automatic test_stall_fill();
        int i;
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_request = STALL_HOLD;
        for (i = 0; i < 12; i++)
            send_point(random_point(i == 11));
    endtask

    function automatic int pick_reg(int top);
        case ($urandom_range(0, 5))
            0: return 0;
            1: return top;
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic test_random_checks(int phases, int per_phase);
        int  phase;
        int  sent;
        int  len;
        int  i;
        point_t p;
        for (phase = 0; phase < phases; phase++)
        begin
            set_config(pick_reg(1023), pick_reg(4095), pick_reg(255), pick_reg(255));
            sent = 0;
            while (sent < per_phase)
            begin
                len = $urandom_range(1, 40);
                if (len > per_phase - sent)
                    len = per_phase - sent;
                send_idle = ($urandom_range(0, 3) != 0);
                recv_idle = ($urandom_range(0, 3) != 0);
                for (i = 0; i < len; i++)
                begin
                    p = random_point(i == len - 1);
                    // An occasional stray or missing end mark breaks the check.
                    if ($urandom_range(0, 19) == 0)
                        p.last = ~p.last;
                    send_point(p);
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_stall_fill();
        test_random_checks(8, 240);
        drain_results();
        $display("Sent %0d points in %0d closed checks over %0d register settings;",
                 points_sent, checks_closed, settings_used);
        $display("%0d points failed their window, one long output stall included.",
                 failing_points);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- tricolour_ratio_point_check.f -----
rtl/core/trpc_pkg.sv
rtl/core/trpc_front.sv
rtl/core/trpc_queue.sv
rtl/core/trpc_back.sv
rtl/core/tricolour_ratio_point_check.sv
dv/tricolour_ratio_point_check_tb.sv
